### rtl/vkqp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vkqp_pkg;

  localparam int KEY_COUNT   = 8;
  localparam int GROUP_COUNT = 4;
  localparam int KEY_W       = 3;
  localparam int GROUP_W     = 3;
  localparam int ISS_W       = 4;
  localparam int MASK_W      = 8;
  localparam int STATUS_W    = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_W       = 64;
  localparam int START_W     = 5;

  localparam logic [STATUS_W-1:0] TIMER_MAX     = 8'hff;
  localparam logic [STATUS_W-1:0] STATUS_RESET  = 8'hff;
  localparam logic [STATUS_W-1:0] PRIO_BASE     = 8'd100;
  localparam logic [STATUS_W-1:0] TIMER_RESTART = 8'd1;
  localparam logic [START_W-1:0]  STARTUP_TICKS = 5'd15;

  typedef enum logic [1:0] {
    KIND_STARTUP,
    KIND_FAULT,
    KIND_FIRST,
    KIND_NORMAL
  } tick_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINAL
  } state_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_VALUES,
    CFG_MAX_VALUES,
    CFG_RESPONSE_TIMES,
    CFG_ANY_VALUE_MASK,
    CFG_GROUPS,
    CFG_PRIORITIES,
    CFG_FORCE_ENABLE,
    CFG_FORCE_KEY
  } cfg_idx_e;

endpackage

`default_nettype wire

### rtl/vkqp_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface vkqp_in_if import vkqp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                mode;
  logic [KEY_W-1:0]    key_index;
  logic [STATUS_W-1:0] key_value;
  logic                low_voltage;
  logic                high_voltage;

  modport source (
    output valid, mode, key_index, key_value, low_voltage, high_voltage,
    input  ready
  );
  modport sink (
    input  valid, mode, key_index, key_value, low_voltage, high_voltage,
    output ready
  );
endinterface

`default_nettype wire

### rtl/vkqp_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface vkqp_out_if import vkqp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] pressed_mask;
  logic [1:0]        tick_kind;

  modport source (
    output valid, pressed_mask, tick_kind,
    input  ready
  );
  modport sink (
    input  valid, pressed_mask, tick_kind,
    output ready
  );
endinterface

`default_nettype wire

### rtl/virtual_key_qualifier_priority_top.sv
// Virtual key qualifier with per-group priority.
// Input transfers on in_i carry either a key status store (mode 0) or a
// tick (mode 1). A store gives no result. Each tick gives exactly one
// result transfer on out_o with the pressed key mask and the tick kind.
// Configuration registers are written through cfg_we_i, cfg_idx_i and
// cfg_data_i; the user must write them only while the block is idle, and
// the block itself does not enforce this. The first 16 ticks after reset
// and voltage fault ticks give their result in the cycle after the
// transfer. Other ticks walk the eight keys through the key state
// memories, one key per cycle with registered reads, and then resolve
// group priorities; the result is registered in ST_FINAL.
// Reset empties the status and timer memories (every entry reads as 0xff),
// clears the start-up counter, the first sample flag and the held mask.
// The result waits in an output register while the receiver stalls; a new
// item is accepted once that register is free or being emptied.
`timescale 1ns / 1ps
`default_nettype none

module virtual_key_qualifier_priority_top import vkqp_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  vkqp_in_if.sink                   in_i,
  vkqp_out_if.source                out_o
);

  logic [CFG_W-1:0]             cfg_min_q, cfg_max_q, cfg_resp_q, cfg_prio_q;
  logic [KEY_COUNT-1:0]         cfg_any_q;
  logic [KEY_COUNT*GROUP_W-1:0] cfg_groups_q;
  logic                         cfg_force_en_q;
  logic [2:0]                   cfg_force_key_q;

  logic [STATUS_W-1:0]   cur_mem [KEY_COUNT];
  logic [2*STATUS_W-1:0] kst_mem [KEY_COUNT];
  logic [KEY_COUNT-1:0]  cur_vld_q, kst_vld_q;
  logic [STATUS_W-1:0]   cur_rd_q;
  logic [2*STATUS_W-1:0] kst_rd_q;
  logic                  cur_rv_q, kst_rv_q;

  state_e               state_q, state_d;
  logic [ISS_W-1:0]     iss_q;
  logic                 p_vld_q;
  logic [KEY_W-1:0]     p_idx_q;
  logic                 first_q;
  logic [KEY_COUNT-1:0] valid_q;
  logic [STATUS_W-1:0]  best_q [2**GROUP_W];
  logic [START_W-1:0]   startup_q;
  logic                 first_done_q;
  logic [MASK_W-1:0]    held_q;
  logic                 out_vld_q;
  logic [MASK_W-1:0]    out_mask_q;
  tick_kind_e           out_kind_q;

  logic                in_acc, out_free, tick_acc, startup_busy, fault, issue;
  logic                out_load;
  logic [STATUS_W-1:0] cur, last, tmr, tmr_new, kmin, kmax, kresp, kprio;
  logic [GROUP_W-1:0]  kgrp;
  logic                hit;
  logic [MASK_W-1:0]   force_bit, final_mask;

  assign out_free     = !out_vld_q || out_o.ready;
  assign in_i.ready   = (state_q == ST_IDLE) && out_free;
  assign in_acc       = in_i.valid && in_i.ready;
  assign tick_acc     = in_acc && in_i.mode;
  assign startup_busy = startup_q <= STARTUP_TICKS;
  assign fault        = in_i.low_voltage || in_i.high_voltage;
  assign issue        = (state_q == ST_WALK) && (iss_q < ISS_W'(KEY_COUNT));
  assign force_bit    = cfg_force_en_q ? (MASK_W'(1) << cfg_force_key_q) : '0;
  assign out_load     = (tick_acc && (startup_busy || fault))
                        || (state_q == ST_FINAL && out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_min_q       <= '0;
      cfg_max_q       <= '0;
      cfg_resp_q      <= '0;
      cfg_any_q       <= '0;
      cfg_groups_q    <= '0;
      cfg_prio_q      <= '0;
      cfg_force_en_q  <= 1'b0;
      cfg_force_key_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_VALUES:     cfg_min_q       <= cfg_data_i;
        CFG_MAX_VALUES:     cfg_max_q       <= cfg_data_i;
        CFG_RESPONSE_TIMES: cfg_resp_q      <= cfg_data_i;
        CFG_ANY_VALUE_MASK: cfg_any_q       <= cfg_data_i[KEY_COUNT-1:0];
        CFG_GROUPS:         cfg_groups_q    <= cfg_data_i[KEY_COUNT*GROUP_W-1:0];
        CFG_PRIORITIES:     cfg_prio_q      <= cfg_data_i;
        CFG_FORCE_ENABLE:   cfg_force_en_q  <= cfg_data_i[0];
        CFG_FORCE_KEY:      cfg_force_key_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // Key state memories: current status, and {last status, press timer}.
  always_ff @(posedge clk_i) begin
    if (in_acc && !in_i.mode) begin
      cur_mem[in_i.key_index] <= in_i.key_value;
    end
    if (issue) begin
      cur_rd_q <= cur_mem[iss_q[KEY_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_vld_q) begin
      kst_mem[p_idx_q] <= {cur, tmr_new};
    end
    if (issue) begin
      kst_rd_q <= kst_mem[iss_q[KEY_W-1:0]];
    end
  end

  always_comb begin
    cur   = cur_rv_q ? cur_rd_q : STATUS_RESET;
    last  = kst_rv_q ? kst_rd_q[2*STATUS_W-1:STATUS_W] : STATUS_RESET;
    tmr   = kst_rv_q ? kst_rd_q[STATUS_W-1:0] : TIMER_MAX;
    kmin  = cfg_min_q[p_idx_q*STATUS_W +: STATUS_W];
    kmax  = cfg_max_q[p_idx_q*STATUS_W +: STATUS_W];
    kresp = cfg_resp_q[p_idx_q*STATUS_W +: STATUS_W];
    kprio = cfg_prio_q[p_idx_q*STATUS_W +: STATUS_W];
    kgrp  = cfg_groups_q[p_idx_q*GROUP_W +: GROUP_W];
    if (first_q) begin
      tmr_new = tmr;
    end else if (cur >= kmin && cur <= kmax) begin
      if (cur != last) begin
        tmr_new = TIMER_RESTART;
      end else if (tmr < TIMER_MAX) begin
        tmr_new = tmr + STATUS_W'(1);
      end else begin
        tmr_new = tmr;
      end
    end else begin
      tmr_new = TIMER_MAX;
    end
    hit = !first_q && (tmr_new == kresp) && (cfg_any_q[p_idx_q] || cur != '0);
  end

  always_comb begin
    final_mask = '0;
    for (int k = 0; k < KEY_COUNT; k++) begin
      if (valid_q[k]
          && cfg_groups_q[k*GROUP_W +: GROUP_W] < GROUP_W'(GROUP_COUNT)
          && cfg_prio_q[k*STATUS_W +: STATUS_W]
             == best_q[cfg_groups_q[k*GROUP_W +: GROUP_W]]) begin
        final_mask[k] = 1'b1;
      end
    end
    if (first_q) begin
      final_mask = '0;
    end
    final_mask = final_mask | force_bit;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (tick_acc && !startup_busy && !fault) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (p_vld_q && p_idx_q == KEY_W'(KEY_COUNT - 1)) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q    <= '0;
      kst_vld_q    <= '0;
      cur_rv_q     <= 1'b0;
      kst_rv_q     <= 1'b0;
      iss_q        <= '0;
      p_vld_q      <= 1'b0;
      p_idx_q      <= '0;
      first_q      <= 1'b0;
      valid_q      <= '0;
      startup_q    <= '0;
      first_done_q <= 1'b0;
      held_q       <= '0;
      out_vld_q    <= 1'b0;
      out_mask_q   <= '0;
      out_kind_q   <= KIND_STARTUP;
      for (int g = 0; g < 2**GROUP_W; g++) begin
        best_q[g] <= PRIO_BASE;
      end
    end else begin
      if (out_vld_q && out_o.ready && !out_load) begin
        out_vld_q <= 1'b0;
      end
      if (in_acc && !in_i.mode
          && {1'b0, in_i.key_index} < (KEY_W + 1)'(KEY_COUNT)) begin
        cur_vld_q[in_i.key_index] <= 1'b1;
      end
      if (tick_acc) begin
        if (startup_busy) begin
          startup_q  <= startup_q + START_W'(1);
          out_vld_q  <= 1'b1;
          out_mask_q <= held_q;
          out_kind_q <= KIND_STARTUP;
        end else if (fault) begin
          held_q     <= force_bit;
          out_vld_q  <= 1'b1;
          out_mask_q <= force_bit;
          out_kind_q <= KIND_FAULT;
        end else begin
          iss_q   <= '0;
          first_q <= !first_done_q;
          valid_q <= '0;
          for (int g = 0; g < 2**GROUP_W; g++) begin
            best_q[g] <= PRIO_BASE;
          end
        end
      end
      p_vld_q <= issue;
      if (issue) begin
        iss_q    <= iss_q + ISS_W'(1);
        p_idx_q  <= iss_q[KEY_W-1:0];
        cur_rv_q <= cur_vld_q[iss_q[KEY_W-1:0]];
        kst_rv_q <= kst_vld_q[iss_q[KEY_W-1:0]];
      end
      if (p_vld_q) begin
        kst_vld_q[p_idx_q] <= 1'b1;
        valid_q[p_idx_q]   <= hit;
        if (hit && kgrp < GROUP_W'(GROUP_COUNT) && kprio < best_q[kgrp]) begin
          best_q[kgrp] <= kprio;
        end
      end
      if (state_q == ST_FINAL && out_free) begin
        held_q       <= final_mask;
        out_vld_q    <= 1'b1;
        out_mask_q   <= final_mask;
        out_kind_q   <= first_q ? KIND_FIRST : KIND_NORMAL;
        first_done_q <= 1'b1;
      end
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.pressed_mask = out_mask_q;
  assign out_o.tick_kind    = out_kind_q;

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> state_q == ST_IDLE)
    else $error("input ready outside idle");

  a_pipe_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_vld_q |-> state_q == ST_WALK)
    else $error("key stage active outside walk");

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iss_q <= ISS_W'(KEY_COUNT))
    else $error("key issue counter overran");

  a_startup_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_kind_q == KIND_STARTUP) |-> out_mask_q == '0)
    else $error("start-up tick reported pressed keys");

endmodule

`default_nettype wire

### dv/tb_virtual_key_qualifier_priority_top.sv
`timescale 1ns / 1ps

module tb_virtual_key_qualifier_priority_top;
  import vkqp_pkg::*;

  localparam logic MODE_STORE = 1'b0;
  localparam logic MODE_TICK  = 1'b1;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic                mode;
    logic [KEY_W-1:0]    key_index;
    logic [STATUS_W-1:0] key_value;
    logic                low_voltage;
    logic                high_voltage;
  } key_item_t;

  typedef struct packed {
    logic [MASK_W-1:0] pressed_mask;
    tick_kind_e        tick_kind;
  } tick_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  vkqp_in_if  in_bus ();
  vkqp_out_if out_bus ();

  virtual_key_qualifier_priority_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  always #4 clk_i = ~clk_i;

  key_item_t    key_items_pending [$];
  tick_result_t tick_results_due [$];
  int           items_queued = 0;
  int           items_taken  = 0;
  int           errors       = 0;
  int           cycle_cnt    = 0;
  int           gap_left     = 0;
  int           stall_left   = 0;
  bit           in_idle_en   = 1'b0;
  bit           out_idle_en  = 1'b0;
  key_item_t    next_item;
  key_item_t    taken_item;
  tick_result_t due;

  logic [CFG_W-1:0]   min_vals   = '0;
  logic [CFG_W-1:0]   max_vals   = '0;
  logic [CFG_W-1:0]   resp_times = '0;
  logic [MASK_W-1:0]  any_bits   = '0;
  logic [23:0]        key_grps   = '0;
  logic [CFG_W-1:0]   key_prios  = '0;
  logic               force_on   = 1'b0;
  logic [KEY_W-1:0]   force_sel  = '0;

  logic [STATUS_W-1:0] status_now  [KEY_COUNT] = '{default: STATUS_RESET};
  logic [STATUS_W-1:0] status_prev [KEY_COUNT] = '{default: STATUS_RESET};
  logic [STATUS_W-1:0] press_time  [KEY_COUNT] = '{default: TIMER_MAX};
  logic [START_W-1:0]  startup_ticks = '0;
  logic                first_done    = 1'b0;
  logic [MASK_W-1:0]   held_keys     = '0;

  logic [STATUS_W-1:0] status_a [KEY_COUNT];
  logic [STATUS_W-1:0] status_b [KEY_COUNT];

  function automatic logic [MASK_W-1:0] resolve_pressed();
    logic [MASK_W-1:0]   valid_keys;
    logic [MASK_W-1:0]   pressed;
    logic [STATUS_W-1:0] best [GROUP_COUNT];
    logic [STATUS_W-1:0] st;
    logic [STATUS_W-1:0] prio;
    logic [GROUP_W-1:0]  grp;
    valid_keys = '0;
    pressed = '0;
    for (int k = 0; k < KEY_COUNT; k++) begin
      st = status_now[k];
      if (st >= min_vals[k*STATUS_W +: STATUS_W] && st <= max_vals[k*STATUS_W +: STATUS_W]) begin
        if (st != status_prev[k]) begin
          press_time[k] = TIMER_RESTART;
        end else if (press_time[k] < TIMER_MAX) begin
          press_time[k] = press_time[k] + 1'b1;
        end
      end else begin
        press_time[k] = TIMER_MAX;
      end
      status_prev[k] = st;
      if (press_time[k] == resp_times[k*STATUS_W +: STATUS_W] && (any_bits[k] || st != '0)) begin
        valid_keys[k] = 1'b1;
      end
    end
    for (int g = 0; g < GROUP_COUNT; g++) begin
      best[g] = PRIO_BASE;
    end
    for (int k = 0; k < KEY_COUNT; k++) begin
      grp = key_grps[k*GROUP_W +: GROUP_W];
      prio = key_prios[k*STATUS_W +: STATUS_W];
      if (valid_keys[k] && grp < GROUP_COUNT) begin
        if (prio < best[grp]) begin
          best[grp] = prio;
        end
      end
    end
    for (int k = 0; k < KEY_COUNT; k++) begin
      grp = key_grps[k*GROUP_W +: GROUP_W];
      prio = key_prios[k*STATUS_W +: STATUS_W];
      if (valid_keys[k] && grp < GROUP_COUNT) begin
        if (prio == best[grp]) begin
          pressed[k] = 1'b1;
        end
      end
    end
    return pressed;
  endfunction

  function automatic void predict_key_item(input key_item_t it);
    tick_result_t r;
    if (it.mode == MODE_STORE) begin
      if (it.key_index < KEY_COUNT) begin
        status_now[it.key_index] = it.key_value;
      end
      return;
    end
    if (startup_ticks <= STARTUP_TICKS) begin
      startup_ticks = startup_ticks + 1'b1;
      r.pressed_mask = held_keys;
      r.tick_kind = KIND_STARTUP;
    end else begin
      if (it.low_voltage || it.high_voltage) begin
        held_keys = '0;
        r.tick_kind = KIND_FAULT;
      end else if (!first_done) begin
        first_done = 1'b1;
        status_prev = status_now;
        held_keys = '0;
        r.tick_kind = KIND_FIRST;
      end else begin
        held_keys = resolve_pressed();
        r.tick_kind = KIND_NORMAL;
      end
      if (force_on) begin
        held_keys[force_sel] = 1'b1;
      end
      r.pressed_mask = held_keys;
    end
    tick_results_due.push_back(r);
  endfunction

  function automatic void queue_item(input logic mode, input logic [KEY_W-1:0] idx,
                                     input logic [STATUS_W-1:0] val, input logic lv,
                                     input logic hv);
    key_item_t it;
    it.mode = mode;
    it.key_index = idx;
    it.key_value = val;
    it.low_voltage = lv;
    it.high_voltage = hv;
    key_items_pending.push_back(it);
    items_queued++;
  endfunction

  function automatic void pick_value_pools();
    logic [STATUS_W-1:0] lo;
    logic [STATUS_W-1:0] hi;
    for (int k = 0; k < KEY_COUNT; k++) begin
      lo = min_vals[k*STATUS_W +: STATUS_W];
      hi = max_vals[k*STATUS_W +: STATUS_W];
      status_a[k] = (lo <= hi) ? STATUS_W'($urandom_range(lo, hi))
                               : STATUS_W'($urandom_range(0, 255));
      if ($urandom_range(0, 1) == 0) begin
        status_b[k] = '0;
      end else begin
        status_b[k] = (lo <= hi) ? STATUS_W'($urandom_range(lo, hi))
                                 : STATUS_W'($urandom_range(0, 255));
      end
    end
  endfunction

  function automatic logic [STATUS_W-1:0] pick_status(input int k);
    case ($urandom_range(0, 7))
      0: return STATUS_W'($urandom_range(0, 255));
      1: return status_b[k];
      2: return status_b[k];
      default: return status_a[k];
    endcase
  endfunction

  function automatic logic [STATUS_W-1:0] pick_prio();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd99;
      2: return PRIO_BASE;
      3: return 8'd101;
      4: return 8'd255;
      default: return STATUS_W'($urandom_range(0, 3));
    endcase
  endfunction

  // Most of the traffic is a few status stores followed by a short run of
  // ticks; the rest is fully random noise.
  function automatic void queue_random_items(input int n_items);
    int            made;
    int            n_st;
    int            n_tk;
    int            k;
    logic          fault;
    logic [1:0]    which;
    made = 0;
    while (made < n_items) begin
      if ($urandom_range(0, 11) == 0) begin
        queue_item(1'($urandom_range(0, 1)), KEY_W'($urandom_range(0, 7)),
                   STATUS_W'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        made++;
      end else begin
        n_st = $urandom_range(0, 2);
        n_tk = $urandom_range(1, 4);
        for (int i = 0; i < n_st; i++) begin
          k = $urandom_range(0, KEY_COUNT - 1);
          queue_item(MODE_STORE, KEY_W'(k), pick_status(k), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
        end
        for (int i = 0; i < n_tk; i++) begin
          fault = ($urandom_range(0, 19) == 0);
          which = 2'($urandom_range(1, 3));
          queue_item(MODE_TICK, KEY_W'($urandom_range(0, 7)),
                     STATUS_W'($urandom_range(0, 255)),
                     fault & which[0], fault & which[1]);
        end
        made += n_st + n_tk;
      end
    end
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    case (idx)
      CFG_MIN_VALUES:     min_vals = data;
      CFG_MAX_VALUES:     max_vals = data;
      CFG_RESPONSE_TIMES: resp_times = data;
      CFG_ANY_VALUE_MASK: any_bits = data[MASK_W-1:0];
      CFG_GROUPS:         key_grps = data[23:0];
      CFG_PRIORITIES:     key_prios = data;
      CFG_FORCE_ENABLE:   force_on = data[0];
      CFG_FORCE_KEY:      force_sel = data[KEY_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [CFG_W-1:0] mins, input logic [CFG_W-1:0] maxs,
                                input logic [CFG_W-1:0] resps, input logic [MASK_W-1:0] anys,
                                input logic [23:0] grps, input logic [CFG_W-1:0] prios,
                                input logic fen, input logic [KEY_W-1:0] fkey);
    write_reg(CFG_MIN_VALUES, mins);
    write_reg(CFG_MAX_VALUES, maxs);
    write_reg(CFG_RESPONSE_TIMES, resps);
    write_reg(CFG_ANY_VALUE_MASK, CFG_W'(anys));
    write_reg(CFG_GROUPS, CFG_W'(grps));
    write_reg(CFG_PRIORITIES, prios);
    write_reg(CFG_FORCE_ENABLE, CFG_W'(fen));
    write_reg(CFG_FORCE_KEY, CFG_W'(fkey));
    @(posedge clk_i);
    cfg_we <= 1'b0;
    pick_value_pools();
  endtask

  task automatic apply_random_settings();
    logic [CFG_W-1:0] mins;
    logic [CFG_W-1:0] maxs;
    logic [CFG_W-1:0] resps;
    logic [CFG_W-1:0] prios;
    logic [23:0]      grps;
    for (int k = 0; k < KEY_COUNT; k++) begin
      mins[k*8 +: 8] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(0, 10));
      case ($urandom_range(0, 3))
        0: maxs[k*8 +: 8] = 8'hff;
        1: maxs[k*8 +: 8] = 8'($urandom_range(0, 255));
        default: maxs[k*8 +: 8] = 8'($urandom_range(mins[k*8 +: 8], 255));
      endcase
      case ($urandom_range(0, 9))
        0: resps[k*8 +: 8] = 8'h00;
        1: resps[k*8 +: 8] = 8'hff;
        default: resps[k*8 +: 8] = 8'($urandom_range(1, 5));
      endcase
      prios[k*8 +: 8] = pick_prio();
      grps[k*3 +: 3] = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(4, 7))
                                                    : 3'($urandom_range(0, 3));
    end
    apply_settings(mins, maxs, resps, MASK_W'($urandom_range(0, 255)), grps, prios,
                   1'($urandom_range(0, 1)), KEY_W'($urandom_range(0, 7)));
  endtask

  task automatic wait_idle();
    while (items_taken != items_queued || tick_results_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input int n_items, input bit in_idle, input bit out_idle);
    in_idle_en = in_idle;
    out_idle_en = out_idle;
    queue_random_items(n_items);
    wait_idle();
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && (!in_bus.valid || in_bus.ready)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_bus.valid <= 1'b0;
      end else if (in_idle_en && $urandom_range(0, 4) == 0) begin
        gap_left = $urandom_range(0, 5);
        in_bus.valid <= 1'b0;
      end else if (key_items_pending.size() != 0) begin
        next_item = key_items_pending.pop_front();
        in_bus.mode <= next_item.mode;
        in_bus.key_index <= next_item.key_index;
        in_bus.key_value <= next_item.key_value;
        in_bus.low_voltage <= next_item.low_voltage;
        in_bus.high_voltage <= next_item.high_voltage;
        in_bus.valid <= 1'b1;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (out_idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // The expectation for an input transfer is queued before any result
  // transfer of the same edge is checked.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) begin
        taken_item.mode = in_bus.mode;
        taken_item.key_index = in_bus.key_index;
        taken_item.key_value = in_bus.key_value;
        taken_item.low_voltage = in_bus.low_voltage;
        taken_item.high_voltage = in_bus.high_voltage;
        predict_key_item(taken_item);
        items_taken++;
      end
      if (out_bus.valid && out_bus.ready) begin
        if (tick_results_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual pressed_mask %02h tick_kind %0d",
                   $time, out_bus.pressed_mask, out_bus.tick_kind);
        end else begin
          due = tick_results_due.pop_front();
          if (out_bus.pressed_mask !== due.pressed_mask) begin
            errors++;
            $display("%0t: pressed_mask mismatch, expected %02h actual %02h",
                     $time, due.pressed_mask, out_bus.pressed_mask);
          end
          if (out_bus.tick_kind !== due.tick_kind) begin
            errors++;
            $display("%0t: tick_kind mismatch, expected %0d actual %0d",
                     $time, due.tick_kind, out_bus.tick_kind);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_MIN_VALUES;
    cfg_data = '0;
    in_bus.valid = 1'b0;
    in_bus.mode = MODE_STORE;
    in_bus.key_index = '0;
    in_bus.key_value = '0;
    in_bus.low_voltage = 1'b0;
    in_bus.high_voltage = 1'b0;
    out_bus.ready = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    apply_settings(64'hf0ff_ffff_ffff_ffff, 64'hf0ff_ffff_ffff_ffff & 64'hf0ff_ffff_ffff_ffff,
                   {8'h01, 8'hff, 8'h02, 8'h01, 8'h00, 8'h03, 8'h02, 8'h01}, 8'h0f,
                   {3'd7, 3'd4, 3'd3, 3'd2, 3'd1, 3'd1, 3'd0, 3'd0},
                   {8'd3, 8'd255, 8'd0, 8'd101, 8'd100, 8'd100, 8'd5, 8'd5}, 1'b1, 3'd5);
    write_reg(CFG_MIN_VALUES, {8'h10, 56'h0});
    @(posedge clk_i);
    cfg_we <= 1'b0;
    pick_value_pools();

    // The start-up ticks ignore the voltage flags and the force bit.
    queue_item(MODE_STORE, 3'd0, 8'h00, 1'b1, 1'b0);
    queue_item(MODE_STORE, 3'd7, 8'hff, 1'b0, 1'b1);
    for (int i = 0; i < 16; i++) begin
      queue_item(MODE_TICK, 3'(i), 8'(i * 17), i[0], i[1]);
    end
    queue_item(MODE_TICK, 3'd0, 8'h00, 1'b1, 1'b0);
    queue_item(MODE_TICK, 3'd7, 8'hff, 1'b0, 1'b1);
    queue_item(MODE_TICK, 3'd0, 8'h00, 1'b0, 1'b0);
    queue_item(MODE_STORE, 3'd3, 8'h80, 1'b0, 1'b0);
    queue_item(MODE_TICK, 3'd0, 8'h00, 1'b0, 1'b0);
    queue_item(MODE_TICK, 3'd0, 8'h00, 1'b0, 1'b0);
    queue_item(MODE_TICK, 3'd0, 8'h00, 1'b0, 1'b0);
    run_phase(250, 1'b1, 1'b1);

    apply_settings('0, '0, '0, '0, '0, '0, 1'b0, 3'd0);
    run_phase(150, 1'b1, 1'b0);

    apply_settings('1, '1, '1, 8'hff, 24'hffffff, '1, 1'b1, 3'd7);
    run_phase(100, 1'b0, 1'b1);

    repeat (3) begin
      apply_random_settings();
      run_phase(300, 1'b1, 1'b1);
    end

    apply_random_settings();
    run_phase(250, 1'b0, 1'b0);

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
